[rtl/core/mgs_pkg.sv]
// shared types, constants and the mask compare for the masked square gradient sum
`timescale 1ns / 1ps

package mgs_pkg;

    localparam int unsigned DEFAULT_MAX_WIDTH = 4096;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned WIDTH_W    = 13;
    localparam int unsigned HEIGHT_W   = 16;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned SQ_W       = 17;
    localparam int unsigned TOTAL_W    = 45;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    // row store entry: older pixel, newer pixel, mask hit
    localparam int unsigned ENTRY_W    = 2 * PIX_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_VALUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_MODE   = 2'd3;

    // register reset values
    localparam logic [WIDTH_W-1:0]  RST_WIDTH     = 13'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT    = 16'd480;
    localparam logic [PIX_W-1:0]    RST_CMP_VALUE = 8'd0;
    localparam logic [MODE_W-1:0]   RST_CMP_MODE  = 3'd0;

    // smallest frame edge
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT = 16'd3;

    // compare modes
    localparam logic [MODE_W-1:0] CMP_EQ = 3'd0;
    localparam logic [MODE_W-1:0] CMP_NE = 3'd1;
    localparam logic [MODE_W-1:0] CMP_GT = 3'd2;
    localparam logic [MODE_W-1:0] CMP_GE = 3'd3;
    localparam logic [MODE_W-1:0] CMP_LT = 3'd4;
    localparam logic [MODE_W-1:0] CMP_LE = 3'd5;

    // item info from the scan stage to the row store stage
    typedef struct packed {
        logic             valid;
        logic             rows_ok;
        logic             vert_ok;
        logic             horiz_ok;
        logic             frame_end;
        logic             hit_now;
        logic [PIX_W-1:0] pix;
    } t_scan;

    // squared terms from the row store stage to the accumulator
    typedef struct packed {
        logic            valid;
        logic            frame_end;
        logic [SQ_W-1:0] sq_sum;
    } t_terms;

    function automatic logic mask_selects(input logic [PIX_W-1:0]  m,
                                          input logic [PIX_W-1:0]  v,
                                          input logic [MODE_W-1:0] mode);
        logic hit;
        hit = 1'b0;
        unique case (mode)
            CMP_EQ:  hit = (m == v);
            CMP_NE:  hit = (m != v);
            CMP_GT:  hit = (m > v);
            CMP_GE:  hit = (m >= v);
            CMP_LT:  hit = (m < v);
            CMP_LE:  hit = (m <= v);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

[rtl/core/mgs_scan_ctrl.sv]
// configuration registers, raster counters and input handshake
`timescale 1ns / 1ps

module mgs_scan_ctrl #(
    parameter int unsigned MAX_WIDTH = mgs_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mgs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mgs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    input  logic [mgs_pkg::PIX_W-1:0]       i_image_pixel,
    input  logic [mgs_pkg::PIX_W-1:0]       i_mask_pixel,
    input  logic                            i_end_busy,
    output logic                            o_in_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_rd_addr,
    output mgs_pkg::t_scan                  o_scan
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = ($clog2(MAX_WIDTH + 1) > mgs_pkg::WIDTH_W)
                               ? $clog2(MAX_WIDTH + 1) : mgs_pkg::WIDTH_W;

    logic [mgs_pkg::WIDTH_W-1:0]  r_width;
    logic [mgs_pkg::HEIGHT_W-1:0] r_height;
    logic [mgs_pkg::PIX_W-1:0]    r_cmp_value;
    logic [mgs_pkg::MODE_W-1:0]   r_cmp_mode;

    logic [CW-1:0]                r_col;
    logic [CW-1:0]                n_col;
    logic [mgs_pkg::HEIGHT_W-1:0] r_row;
    logic [mgs_pkg::HEIGHT_W-1:0] n_row;
    mgs_pkg::t_scan               r_scan;

    logic [WW-1:0]                w_ext;
    logic [WW-1:0]                w_eff;
    logic [WW-1:0]                c_eff;
    logic [mgs_pkg::HEIGHT_W-1:0] h_eff;
    logic                         col_end;
    logic                         row_end;
    logic                         frame_end;
    logic                         accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= mgs_pkg::RST_WIDTH;
            r_height    <= mgs_pkg::RST_HEIGHT;
            r_cmp_value <= mgs_pkg::RST_CMP_VALUE;
            r_cmp_mode  <= mgs_pkg::RST_CMP_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mgs_pkg::REG_WIDTH:     r_width     <= i_cfg_data[mgs_pkg::WIDTH_W-1:0];
                mgs_pkg::REG_HEIGHT:    r_height    <= i_cfg_data[mgs_pkg::HEIGHT_W-1:0];
                mgs_pkg::REG_CMP_VALUE: r_cmp_value <= i_cfg_data[mgs_pkg::PIX_W-1:0];
                mgs_pkg::REG_CMP_MODE:  r_cmp_mode  <= i_cfg_data[mgs_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the frame size into the supported range
    always_comb begin
        w_ext = WW'(r_width);
        if (w_ext < WW'(3)) begin
            w_eff = WW'(3);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff = (r_height < mgs_pkg::MIN_HEIGHT) ? mgs_pkg::MIN_HEIGHT : r_height;
    end

    // column past a shrunken width is pulled back to the last column
    assign c_eff     = (WW'(r_col) >= w_eff) ? (w_eff - WW'(1)) : WW'(r_col);
    assign col_end   = (c_eff >= w_eff - WW'(1));
    assign row_end   = (r_row >= h_eff - mgs_pkg::HEIGHT_W'(1));
    assign frame_end = col_end && row_end;

    // only a frame's last pixel waits, and only while another total is pending
    assign o_in_ready = !(frame_end && i_end_busy);
    assign accept     = i_in_valid && o_in_ready;
    assign o_rd_addr  = c_eff[CW-1:0];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : (r_row + mgs_pkg::HEIGHT_W'(1));
            end else begin
                n_col = CW'(c_eff + WW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_scan.valid <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_scan.valid <= accept;
        end
        if (accept) begin
            r_scan.rows_ok   <= (r_row >= mgs_pkg::HEIGHT_W'(2));
            r_scan.vert_ok   <= (c_eff != '0) && (c_eff + WW'(2) <= w_eff);
            r_scan.horiz_ok  <= (c_eff >= WW'(2));
            r_scan.frame_end <= frame_end;
            r_scan.hit_now   <= mgs_pkg::mask_selects(i_mask_pixel, r_cmp_value, r_cmp_mode);
            r_scan.pix       <= i_image_pixel;
        end
    end

    assign o_scan = r_scan;

endmodule

[rtl/core/mgs_row_store.sv]
// row store memory with read-modify-write and the squared difference terms
`timescale 1ns / 1ps

module mgs_row_store #(
    parameter int unsigned MAX_WIDTH = mgs_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  mgs_pkg::t_scan               i_scan,
    output mgs_pkg::t_terms              o_terms
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = mgs_pkg::PIX_W;

    logic [mgs_pkg::ENTRY_W-1:0] r_mem [MAX_WIDTH];
    logic [mgs_pkg::ENTRY_W-1:0] r_rd_data;
    logic [CW-1:0]               r_wr_addr;
    logic [2*PW-1:0]             r_left_pix;
    logic                        r_left_hit;
    mgs_pkg::t_terms             r_terms;

    logic [PW-1:0]               above;
    logic [PW-1:0]               two_above;
    logic                        hit_above;
    logic [PW-1:0]               left_far;
    logic [PW-1:0]               diff_v;
    logic [PW-1:0]               diff_h;
    logic [2*PW-1:0]             sq_v;
    logic [2*PW-1:0]             sq_h;
    logic [mgs_pkg::SQ_W-1:0]    n_sq_sum;

    // read every cycle; the address only moves on an accepted transaction
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        r_wr_addr <= i_rd_addr;
        if (i_scan.valid) begin
            r_mem[r_wr_addr] <= {above, i_scan.pix, i_scan.hit_now};
        end
    end

    assign two_above = r_rd_data[mgs_pkg::ENTRY_W-1 -: PW];
    assign above     = r_rd_data[PW:1];
    assign hit_above = r_rd_data[0];
    assign left_far  = r_left_pix[2*PW-1:PW];

    always_comb begin
        diff_v = (two_above > i_scan.pix) ? (two_above - i_scan.pix)
                                          : (i_scan.pix - two_above);
        diff_h = (left_far > above) ? (left_far - above) : (above - left_far);
        sq_v   = (2*PW)'(diff_v) * (2*PW)'(diff_v);
        sq_h   = (2*PW)'(diff_h) * (2*PW)'(diff_h);
        if (!(i_scan.rows_ok && i_scan.vert_ok && hit_above)) begin
            sq_v = '0;
        end
        if (!(i_scan.rows_ok && i_scan.horiz_ok && r_left_hit)) begin
            sq_h = '0;
        end
        n_sq_sum = mgs_pkg::SQ_W'(sq_v) + mgs_pkg::SQ_W'(sq_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_pix    <= '0;
            r_left_hit    <= 1'b0;
            r_terms.valid <= 1'b0;
        end else begin
            r_terms.valid <= i_scan.valid;
            if (i_scan.valid) begin
                r_left_pix <= {r_left_pix[PW-1:0], above};
                r_left_hit <= hit_above;
            end
        end
        if (i_scan.valid) begin
            r_terms.frame_end <= i_scan.frame_end;
            r_terms.sq_sum    <= n_sq_sum;
        end
    end

    assign o_terms = r_terms;

endmodule

[rtl/core/mgs_accum.sv]
// running frame total and the result output register
`timescale 1ns / 1ps

module mgs_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mgs_pkg::t_terms              i_terms,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [mgs_pkg::TOTAL_W-1:0]  o_gradient_total
);

    logic [mgs_pkg::TOTAL_W-1:0] r_total;
    logic [mgs_pkg::TOTAL_W-1:0] n_total;
    logic [mgs_pkg::TOTAL_W-1:0] r_out_total;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        load_out;

    // wraps modulo the total width
    assign n_total  = r_total + mgs_pkg::TOTAL_W'(i_terms.sq_sum);
    assign load_out = i_terms.valid && i_terms.frame_end;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_terms.valid) begin
                r_total <= i_terms.frame_end ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_total <= n_total;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_gradient_total = r_out_total;

endmodule

[rtl/core/masked_square_gradient_sum.sv]
// top level of the masked square gradient sum over one frame
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_image_pixel, i_mask_pixel
//  out      output     o_out_valid / i_out_ready  o_gradient_total
//  cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one pixel per clock but for a held-off last pixel; the row store is read at the accept edge
// and written back the next cycle, so each column sees one read-modify-write per row.
// a frame total passes the scan, terms and output registers after its last pixel is accepted.
// only a frame's last pixel is held off, and only while an earlier total is pending.
// synchronous reset clears counters, pipeline valids and the total; the row store
// is not cleared, every entry is written before it is read.
`timescale 1ns / 1ps

module masked_square_gradient_sum #(
    parameter int unsigned MAX_WIDTH = mgs_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mgs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mgs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mgs_pkg::PIX_W-1:0]       i_image_pixel,
    input  logic [mgs_pkg::PIX_W-1:0]       i_mask_pixel,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mgs_pkg::TOTAL_W-1:0]     o_gradient_total
);

    logic [$clog2(MAX_WIDTH)-1:0] rd_addr;
    mgs_pkg::t_scan               scan;
    mgs_pkg::t_terms              terms;
    logic                         scan_end;
    logic                         terms_end;
    logic                         end_busy;

    assign scan_end  = scan.valid && scan.frame_end;
    assign terms_end = terms.valid && terms.frame_end;
    // a frame end in flight or a total waiting to be taken
    assign end_busy  = scan_end || terms_end || o_out_valid;

    mgs_scan_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_image_pixel (i_image_pixel),
        .i_mask_pixel  (i_mask_pixel),
        .i_end_busy    (end_busy),
        .o_in_ready    (o_in_ready),
        .o_rd_addr     (rd_addr),
        .o_scan        (scan)
    );

    mgs_row_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_scan    (scan),
        .o_terms   (terms)
    );

    mgs_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_terms          (terms),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_gradient_total (o_gradient_total)
    );

    // the pipeline never stalls once a transaction is accepted
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan.valid |=> terms.valid)
        else $error("row store stage dropped a transaction");

    // a new total never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        terms_end |-> !o_out_valid)
        else $error("frame total overwrote a pending result");

    // at most one frame end between input and output
    a_one_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({scan_end, terms_end, o_out_valid}) <= 1)
        else $error("more than one frame end in flight");

    // consecutive transactions never touch the same row store entry
    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !scan.valid || (rd_addr != $past(rd_addr))
            || !(i_in_valid && o_in_ready))
        else $error("row store read and write hit the same entry");

endmodule

[dv/tb_top.sv]
// self-checking testbench for the masked square gradient sum block
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned MAX_W         = mgs_pkg::DEFAULT_MAX_WIDTH;
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned RANDOM_PIXELS = 1700;
    localparam int unsigned MIN_FRAMES    = 40;
    localparam int unsigned IDLE_PCT      = 23;
    // modes outside the defined set select nothing
    localparam logic [mgs_pkg::MODE_W-1:0] CMP_NONE_LO = 3'd6;
    localparam logic [mgs_pkg::MODE_W-1:0] CMP_NONE_HI = 3'd7;

    class gradient_sum_tracker;
        logic [mgs_pkg::WIDTH_W-1:0]  width_reg;
        logic [mgs_pkg::HEIGHT_W-1:0] height_reg;
        logic [mgs_pkg::PIX_W-1:0]    cmp_value;
        logic [mgs_pkg::MODE_W-1:0]   cmp_mode;
        bit [mgs_pkg::PIX_W-1:0]      two_up_row [MAX_W];
        bit [mgs_pkg::PIX_W-1:0]      one_up_row [MAX_W];
        bit                           hit_row [MAX_W];
        bit [2*mgs_pkg::PIX_W-1:0]    left_pair;
        bit                           left_hit;
        int unsigned                  col;
        int unsigned                  row;
        bit [mgs_pkg::TOTAL_W-1:0]    frame_sum;
        bit [mgs_pkg::TOTAL_W-1:0]    pending_totals [$];
        int unsigned                  mismatches;

        function new();
            width_reg  = mgs_pkg::RST_WIDTH;
            height_reg = mgs_pkg::RST_HEIGHT;
            cmp_value  = mgs_pkg::RST_CMP_VALUE;
            cmp_mode   = mgs_pkg::RST_CMP_MODE;
            left_pair  = '0;
            left_hit   = 1'b0;
            col        = 0;
            row        = 0;
            frame_sum  = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [mgs_pkg::CFG_IDX_W-1:0] idx,
                                logic [mgs_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mgs_pkg::REG_WIDTH:     width_reg  = data[mgs_pkg::WIDTH_W-1:0];
                mgs_pkg::REG_HEIGHT:    height_reg = data[mgs_pkg::HEIGHT_W-1:0];
                mgs_pkg::REG_CMP_VALUE: cmp_value  = data[mgs_pkg::PIX_W-1:0];
                mgs_pkg::REG_CMP_MODE:  cmp_mode   = data[mgs_pkg::MODE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit mask_hit(logic [mgs_pkg::PIX_W-1:0] m);
            case (cmp_mode)
                mgs_pkg::CMP_EQ: return m == cmp_value;
                mgs_pkg::CMP_NE: return m != cmp_value;
                mgs_pkg::CMP_GT: return m > cmp_value;
                mgs_pkg::CMP_GE: return m >= cmp_value;
                mgs_pkg::CMP_LT: return m < cmp_value;
                mgs_pkg::CMP_LE: return m <= cmp_value;
                default:         return 1'b0;
            endcase
        endfunction

        function int unsigned diff_squared(bit [mgs_pkg::PIX_W-1:0] a,
                                           bit [mgs_pkg::PIX_W-1:0] b);
            int d;
            d = int'(a) - int'(b);
            if (d < 0) d = -d;
            return d * d;
        endfunction

        function void take_pixel(logic [mgs_pkg::PIX_W-1:0] pix,
                                 logic [mgs_pkg::PIX_W-1:0] mask);
            int unsigned             w;
            int unsigned             h;
            int unsigned             c;
            int unsigned             r;
            bit [mgs_pkg::PIX_W-1:0] above;
            bit [mgs_pkg::PIX_W-1:0] two_above;
            bit                      hit_above;
            w = 32'(width_reg);
            h = 32'(height_reg);
            if (w < 3) w = 3;
            if (w > MAX_W) w = MAX_W;
            if (h < 3) h = 3;
            c = (col >= w) ? w - 1 : col;
            r = row;
            above     = one_up_row[c];
            two_above = two_up_row[c];
            hit_above = hit_row[c];
            // vertical term of centre one row up, horizontal term of its left neighbour
            if (r >= 2) begin
                if (c >= 1 && c + 2 <= w && hit_above)
                    frame_sum += mgs_pkg::TOTAL_W'(diff_squared(two_above, pix));
                if (c >= 2 && left_hit)
                    frame_sum += mgs_pkg::TOTAL_W'(
                        diff_squared(left_pair[2*mgs_pkg::PIX_W-1:mgs_pkg::PIX_W], above));
            end
            left_pair     = {left_pair[mgs_pkg::PIX_W-1:0], above};
            left_hit      = hit_above;
            two_up_row[c] = above;
            one_up_row[c] = pix;
            hit_row[c]    = mask_hit(mask);
            if (c + 1 >= w) begin
                col = 0;
                if (r + 1 >= h) begin
                    pending_totals.push_back(frame_sum);
                    frame_sum = '0;
                    row = 0;
                end else begin
                    row = (r + 1) & 16'hFFFF;
                end
            end else begin
                col = c + 1;
            end
        endfunction

        function void check_total(logic [mgs_pkg::TOTAL_W-1:0] actual);
            bit [mgs_pkg::TOTAL_W-1:0] want;
            if (pending_totals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame total %0d at %0t", actual, $realtime);
            end else begin
                want = pending_totals.pop_front();
                if (actual !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame total mismatch: expected %0d, got %0d at %0t",
                                 want, actual, $realtime);
                end
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mgs_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [mgs_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [mgs_pkg::PIX_W-1:0]       i_image_pixel;
    logic [mgs_pkg::PIX_W-1:0]       i_mask_pixel;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [mgs_pkg::TOTAL_W-1:0]     o_gradient_total;

    gradient_sum_tracker tracker;
    bit                  calm;
    int unsigned         stall_cycles;

    masked_square_gradient_sum dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_image_pixel    (i_image_pixel),
        .i_mask_pixel     (i_mask_pixel),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_gradient_total (o_gradient_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random back-pressure, checks every transaction
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                tracker.check_total(o_gradient_total);
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("masked_square_gradient_sum regression: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_pixel(input logic [mgs_pkg::PIX_W-1:0] pix,
                              input logic [mgs_pkg::PIX_W-1:0] mask);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_image_pixel <= pix;
        i_mask_pixel  <= mask;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_pixel(pix, mask);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending_totals.size() != 0) @(posedge i_clk);
        // block may still hold a partial frame in its pipeline
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mgs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mgs_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // upper data bits beyond each register are random and must be dropped
    task automatic configure(input logic [mgs_pkg::WIDTH_W-1:0] w,
                             input logic [mgs_pkg::HEIGHT_W-1:0] h,
                             input logic [mgs_pkg::PIX_W-1:0] v,
                             input logic [mgs_pkg::MODE_W-1:0] m);
        logic [mgs_pkg::CFG_DATA_W-1:0] junk;
        junk = mgs_pkg::CFG_DATA_W'($urandom);
        write_reg(mgs_pkg::REG_WIDTH, {junk[mgs_pkg::CFG_DATA_W-1:mgs_pkg::WIDTH_W], w});
        write_reg(mgs_pkg::REG_HEIGHT, h);
        write_reg(mgs_pkg::REG_CMP_VALUE, {junk[mgs_pkg::CFG_DATA_W-1:mgs_pkg::PIX_W], v});
        write_reg(mgs_pkg::REG_CMP_MODE, {junk[mgs_pkg::CFG_DATA_W-1:mgs_pkg::MODE_W], m});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input int unsigned n_pixels);
        logic [mgs_pkg::PIX_W-1:0] pix;
        logic [mgs_pkg::PIX_W-1:0] mask;
        for (int unsigned i = 0; i < n_pixels; i++) begin
            case ($urandom_range(6))
                0:       pix = '0;
                1:       pix = '1;
                default: pix = mgs_pkg::PIX_W'($urandom_range(255));
            endcase
            // keep masks near the threshold so every compare mode flips often
            case ($urandom_range(3))
                0:       mask = tracker.cmp_value;
                1:       mask = tracker.cmp_value + 8'd1;
                2:       mask = tracker.cmp_value - 8'd1;
                default: mask = mgs_pkg::PIX_W'($urandom_range(255));
            endcase
            send_pixel(pix, mask);
        end
    endtask

    initial begin
        int unsigned               w;
        int unsigned               h;
        int unsigned               cols;
        int unsigned               rows;
        int unsigned               sent;
        int unsigned               frames;
        logic [mgs_pkg::PIX_W-1:0] v;
        tracker       = new();
        calm          = 1'b0;
        stall_cycles  = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = mgs_pkg::REG_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_image_pixel = '0;
        i_mask_pixel  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero width and height clamp to 3x3; centre selected with steepest gradients
        configure(13'd0, 16'd0, 8'd0, mgs_pkg::CMP_EQ);
        for (int unsigned r = 0; r < 3; r++)
            for (int unsigned c = 0; c < 3; c++)
                send_pixel((r == 2 || c == 2) ? 8'hFF : 8'h00, 8'h00);
        drain();
        configure(13'd3, 16'd3, 8'hFF, CMP_NONE_LO);
        for (int unsigned i = 0; i < 9; i++)
            send_pixel(mgs_pkg::PIX_W'($urandom_range(255)), 8'hFF);
        cols = 3;
        rows = 3;

        sent   = 0;
        frames = 0;
        while (sent < RANDOM_PIXELS || frames < MIN_FRAMES) begin
            calm = (frames >= 12 && frames < 24);
            if (frames == 0 || $urandom_range(1)) begin
                case ($urandom_range(9))
                    0:       w = $urandom_range(2);
                    1, 2:    w = $urandom_range(40, 9);
                    default: w = $urandom_range(8, 3);
                endcase
                case ($urandom_range(9))
                    0:       h = $urandom_range(2);
                    1:       h = $urandom_range(24, 9);
                    default: h = $urandom_range(8, 3);
                endcase
                case ($urandom_range(3))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    default: v = mgs_pkg::PIX_W'($urandom_range(255));
                endcase
                drain();
                configure(mgs_pkg::WIDTH_W'(w), mgs_pkg::HEIGHT_W'(h), v,
                          mgs_pkg::MODE_W'($urandom_range(7)));
                cols = (w < 3) ? 3 : w;
                rows = (h < 3) ? 3 : h;
            end
            send_frame(cols * rows);
            sent += cols * rows;
            frames++;
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.pending_totals.size() != 0)
            $display("%0d frame totals never arrived", tracker.pending_totals.size());
        if (tracker.mismatches == 0 && tracker.pending_totals.size() == 0) begin
            $display("masked_square_gradient_sum regression: pass");
        end else begin
            $display("masked_square_gradient_sum regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mgs_pkg.sv
rtl/core/mgs_scan_ctrl.sv
rtl/core/mgs_row_store.sv
rtl/core/mgs_accum.sv
rtl/core/masked_square_gradient_sum.sv
dv/tb_top.sv
